FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the piecewise linear map.
// Define NO_ASSERTIONS to compile every check away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge outside reset.
`define PLM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define PLM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define PLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/plm_pkg.sv
// Package of the piecewise linear map: word types, command and status
// structs, operation codes and default sizes. Depends on nothing.
package plm_pkg;

    // Field widths fixed by the interface.
    localparam int DATA_W  = 32;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int INDEX_W = 4;
    localparam int CFG_W   = 5;

    // Defaults for the top level parameters.
    localparam int DEF_MAX_POINTS = 16;
    localparam int DEF_FRAC_BITS  = 16;

    // Smallest number of breakpoint pairs that forms a map.
    localparam int CFG_POINTS_MIN = 2;

    // Operation codes of an input word.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MAP  = 1'b1;

    // Saturation limits of a result.
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                     operation;
        logic [INDEX_W-1:0]       point_index;
        logic signed [DATA_W-1:0] point_x;
        logic signed [DATA_W-1:0] point_y;
        logic signed [DATA_W-1:0] datum;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] mapped_value;
        logic                     degenerate_segment;
        logic                     saturated;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // write one breakpoint pair
        logic start;      // latch the datum, rewind the scan
        logic step;       // shift current entry into previous, advance index
        logic hit;        // exact match: result is the current y
        logic dif;        // register the segment differences
        logic degen;      // zero-width segment: result is y0
        logic mul;        // register the magnitude product
        logic div_start;  // launch the divider
        logic sum;        // form the saturated result
        logic emit;       // move the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic gt;         // entry read is greater than the datum
        logic eq;         // entry read equals the datum
        logic first;      // scan is at entry zero
        logic last;       // scan is at the last entry in use
        logic dx_zero;    // segment has zero x width
        logic div_done;   // divider quotient is ready
    } t_dp_sts;

endpackage

FILE: hw/rtl/plm_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies.
module plm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/plm_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on plm_pkg for the operand widths.
module plm_div import plm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_num,
    input  logic [DATA_W-1:0] i_den,
    output logic [DATA_W-1:0] o_quo,
    output logic              o_ovf,
    output logic              o_done
);

    localparam int CNT_W = $clog2(DATA_W);

    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_den;
    logic              r_ovf;

    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              ge;
    logic [DATA_W-1:0] n_rem;

    // One restoring step: shift in the next numerator bit, try a subtract.
    always_comb begin
        trial = {r_rem, r_quo[DATA_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
        n_rem = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
    end

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operands, partial remainder and quotient. A quotient that would not
    // fit the word is flagged at start and the iterations are ignored.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[PROD_W-1:DATA_W];
            r_quo <= i_num[DATA_W-1:0];
            r_den <= i_den;
            r_ovf <= i_num[PROD_W-1:DATA_W] >= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DATA_W-2:0], ge};
        end
    end

    assign o_quo  = r_quo;
    assign o_ovf  = r_ovf;
    assign o_done = r_done;

endmodule

FILE: hw/rtl/plm_datapath.sv
// Datapath of the piecewise linear map: breakpoint tables, scan compare,
// segment differences, multiplier, divider and saturation.
// Depends on plm_pkg, plm_ram and plm_div.
module plm_datapath import plm_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  t_in_word         i_in_word,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_dp_sts          o_sts,
    output t_out_word        o_out_word
);

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [DATA_W-1:0] ONE_VAL  = DATA_W'(1) << FRAC_BITS;
    localparam logic [DATA_W-1:0] ZERO_VAL = '0;

    // Control state.
    logic          r_wr0;
    logic          r_wr1;
    logic [CW-1:0] r_points;
    logic [IW-1:0] r_idx;

    // Payload registers.
    logic signed [DATA_W-1:0] r_d;
    logic signed [DATA_W-1:0] r_px;
    logic signed [DATA_W-1:0] r_py;
    logic signed [DATA_W-1:0] r_cx;
    logic signed [DATA_W-1:0] r_cy;
    logic [DATA_W-1:0]        r_mdd;
    logic [DATA_W-1:0]        r_mdy;
    logic [DATA_W-1:0]        r_mdx;
    logic                     r_neg;
    logic [PROD_W-1:0]        r_prod;
    t_out_word                r_res;
    t_out_word                r_out;

    logic [31:0]              idx_ext;
    logic                     idx_ok;
    logic                     wr_en;
    logic [IW-1:0]            waddr;
    logic [DATA_W-1:0]        ram_x;
    logic [DATA_W-1:0]        ram_y;
    logic signed [DATA_W-1:0] cx;
    logic signed [DATA_W-1:0] cy;
    logic [31:0]              cfg_val;
    logic [31:0]              cfg_clamp;
    logic signed [DATA_W:0]   dd;
    logic signed [DATA_W:0]   dy;
    logic signed [DATA_W:0]   dx;
    logic [DATA_W:0]          add_dd;
    logic [DATA_W:0]          add_dy;
    logic [DATA_W:0]          add_dx;
    logic [DATA_W-1:0]        quo;
    logic                     ovf;
    logic                     div_done;
    logic signed [DATA_W+1:0] y0e;
    logic signed [DATA_W+1:0] qe;
    logic signed [DATA_W+1:0] s;
    logic                     sat_hi;
    logic                     sat_lo;
    t_out_word                sum_res;

    // Load address decode; positions beyond the table are dropped.
    always_comb begin
        idx_ext = 32'(i_in_word.point_index);
        idx_ok  = idx_ext < 32'(MAX_POINTS);
        wr_en   = i_cmd.load && idx_ok;
        waddr   = idx_ext[IW-1:0];
    end

    plm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_POINTS),
        .AW    (IW)
    ) u_ram_x (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (waddr),
        .i_wdata (i_in_word.point_x),
        .i_raddr (r_idx),
        .o_rdata (ram_x)
    );

    plm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_POINTS),
        .AW    (IW)
    ) u_ram_y (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (waddr),
        .i_wdata (i_in_word.point_y),
        .i_raddr (r_idx),
        .o_rdata (ram_y)
    );

    // Entries zero and one read as the identity map until first written.
    always_comb begin
        if (r_idx == '0 && !r_wr0) begin
            cx = ZERO_VAL;
            cy = ZERO_VAL;
        end else if (r_idx == IW'(1) && !r_wr1) begin
            cx = ONE_VAL;
            cy = ONE_VAL;
        end else begin
            cx = ram_x;
            cy = ram_y;
        end
    end

    // Register write with clamping to the usable range.
    always_comb begin
        cfg_val = 32'(i_cfg_data);
        if (cfg_val < 32'(CFG_POINTS_MIN)) begin
            cfg_clamp = 32'(CFG_POINTS_MIN);
        end else if (cfg_val > 32'(MAX_POINTS)) begin
            cfg_clamp = 32'(MAX_POINTS);
        end else begin
            cfg_clamp = cfg_val;
        end
    end

    // Control state: written flags, point count and scan index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr0    <= 1'b0;
            r_wr1    <= 1'b0;
            r_points <= CW'(CFG_POINTS_MIN);
            r_idx    <= '0;
        end else begin
            if (wr_en && idx_ext == 32'd0) begin
                r_wr0 <= 1'b1;
            end
            if (wr_en && idx_ext == 32'd1) begin
                r_wr1 <= 1'b1;
            end
            if (i_cfg_we) begin
                r_points <= cfg_clamp[CW-1:0];
            end
            if (i_cmd.start) begin
                r_idx <= '0;
            end else if (i_cmd.step) begin
                r_idx <= r_idx + IW'(1);
            end
        end
    end

    // Signed segment differences and their magnitudes.
    always_comb begin
        dd     = {r_d[DATA_W-1], r_d} - {r_px[DATA_W-1], r_px};
        dy     = {r_cy[DATA_W-1], r_cy} - {r_py[DATA_W-1], r_py};
        dx     = {r_cx[DATA_W-1], r_cx} - {r_px[DATA_W-1], r_px};
        add_dd = dd[DATA_W] ? -dd : dd;
        add_dy = dy[DATA_W] ? -dy : dy;
        add_dx = dx[DATA_W] ? -dx : dx;
    end

    plm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_prod),
        .i_den   (r_mdx),
        .o_quo   (quo),
        .o_ovf   (ovf),
        .o_done  (div_done)
    );

    // Apply the signed quotient to y0 and saturate to the word range.
    always_comb begin
        y0e    = {{2{r_py[DATA_W-1]}}, r_py};
        qe     = {2'b00, quo};
        s      = r_neg ? (y0e - qe) : (y0e + qe);
        sat_hi = !s[DATA_W+1] && (s[DATA_W:DATA_W-1] != 2'b00);
        sat_lo = s[DATA_W+1] && (s[DATA_W:DATA_W-1] != 2'b11);
        sum_res.degenerate_segment = 1'b0;
        if (ovf) begin
            sum_res.mapped_value = r_neg ? VAL_MIN : VAL_MAX;
            sum_res.saturated    = 1'b1;
        end else if (sat_hi) begin
            sum_res.mapped_value = VAL_MAX;
            sum_res.saturated    = 1'b1;
        end else if (sat_lo) begin
            sum_res.mapped_value = VAL_MIN;
            sum_res.saturated    = 1'b1;
        end else begin
            sum_res.mapped_value = s[DATA_W-1:0];
            sum_res.saturated    = 1'b0;
        end
    end

    // Payload registers of the scan and the arithmetic.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_d <= i_in_word.datum;
        end
        if (i_cmd.step) begin
            r_px <= r_cx;
            r_py <= r_cy;
            r_cx <= cx;
            r_cy <= cy;
        end
        if (i_cmd.dif) begin
            r_mdd <= add_dd[DATA_W-1:0];
            r_mdy <= add_dy[DATA_W-1:0];
            r_mdx <= add_dx[DATA_W-1:0];
            r_neg <= dd[DATA_W] ^ dy[DATA_W] ^ dx[DATA_W];
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_mdd) * PROD_W'(r_mdy);
        end
        if (i_cmd.hit) begin
            r_res.mapped_value       <= cy;
            r_res.degenerate_segment <= 1'b0;
            r_res.saturated          <= 1'b0;
        end else if (i_cmd.degen) begin
            r_res.mapped_value       <= r_py;
            r_res.degenerate_segment <= 1'b1;
            r_res.saturated          <= 1'b0;
        end else if (i_cmd.sum) begin
            r_res <= sum_res;
        end
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    // Status for the controller.
    always_comb begin
        o_sts.gt       = cx > r_d;
        o_sts.eq       = cx == r_d;
        o_sts.first    = r_idx == '0;
        o_sts.last     = (32'(r_idx) + 32'd1) == 32'(r_points);
        o_sts.dx_zero  = r_cx == r_px;
        o_sts.div_done = div_done;
    end

    assign o_out_word = r_out;

endmodule

FILE: hw/rtl/plm_ctrl.sv
// Controller of the piecewise linear map: sequences the scan, the
// arithmetic and the output handshake. Depends on plm_pkg.
module plm_ctrl import plm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_op,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_in_ready,
    output logic    o_out_valid
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_CMP  = 4'd2;
    localparam logic [3:0] S_FRD  = 4'd3;
    localparam logic [3:0] S_FCAP = 4'd4;
    localparam logic [3:0] S_DIF  = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_DVS  = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_SUM  = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_dp_cmd    cmd;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == OP_LOAD) begin
                        cmd.load = 1'b1;
                    end else begin
                        cmd.start = 1'b1;
                        n_state   = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_sts.eq) begin
                    cmd.hit = 1'b1;
                    n_state = S_DONE;
                end else if (i_sts.gt && i_sts.first) begin
                    // Datum lies left of the table: fetch entry one as well.
                    cmd.step = 1'b1;
                    n_state  = S_FRD;
                end else if (i_sts.gt || i_sts.last) begin
                    cmd.step = 1'b1;
                    n_state  = S_DIF;
                end else begin
                    cmd.step = 1'b1;
                    n_state  = S_RD;
                end
            end
            S_FRD: begin
                n_state = S_FCAP;
            end
            S_FCAP: begin
                cmd.step = 1'b1;
                n_state  = S_DIF;
            end
            S_DIF: begin
                cmd.dif = 1'b1;
                if (i_sts.dx_zero) begin
                    cmd.degen = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_DVS;
            end
            S_DVS: begin
                cmd.div_start = 1'b1;
                n_state       = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                cmd.sum = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                // Wait until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    cmd.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register occupancy.
    always_comb begin
        if (cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

FILE: hw/rtl/piecewise_linear_map.sv
// Top level of the piecewise linear map: controller plus datapath.
// Depends on plm_pkg, plm_ctrl, plm_datapath and assert_macros.svh.
//
//   Channel  Direction  Handshake                  Word
//   in       input      i_in_valid / o_in_ready    i_in_word  (t_in_word)
//   out      output     o_out_valid / i_out_ready  o_out_word (t_out_word)
//   cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_data (points_in_use)
//
// A load word is written while idle and the next word is taken right after it.
// A map word scans the table with one read and one compare per entry visited
// (a datum left of the table reads two entries), then forms the differences,
// a 32x32 multiply, a one bit per cycle divide, the sum and the hand-off
// to the output register. An exact match goes from the compare straight to
// the hand-off, and a zero-width segment goes there from the differences.
// Reset is synchronous and restores the identity map with two points.
// A finished result waits in the output register while the next word is
// taken; a further result holds the controller until that register frees.
`include "assert_macros.svh"

module piecewise_linear_map import plm_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_word        o_out_word,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // The register port never stalls.
    assign o_cfg_ready = 1'b1;

    plm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_in_word.operation),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    plm_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_word  (i_in_word),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_sts      (sts),
        .o_out_word (o_out_word)
    );

    // A map word occupies the block, a load word does not.
    `PLM_ASSERT_NEXT(a_map_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && i_in_word.operation == OP_MAP, !o_in_ready)
    `PLM_ASSERT_NEXT(a_load_free, i_clk, i_rst_n, i_in_valid && o_in_ready && i_in_word.operation == OP_LOAD, o_in_ready)

    // A result is never both degenerate and saturated.
    `PLM_ASSERT_IMPLY(a_flags_excl, i_clk, i_rst_n, o_out_valid, !(o_out_word.degenerate_segment && o_out_word.saturated))

endmodule

FILE: dv/tb_piecewise_linear_map.sv
// Testbench of piecewise_linear_map: directed and random load and map words,
// each result checked against an interpolation predictor kept in step here.
// Depends on plm_pkg and the piecewise_linear_map RTL.
module tb_piecewise_linear_map;
    import plm_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 100;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int ERRORS_SHOWN   = 10;
    localparam int SEGMENT_WORDS  = 92;
    localparam int MAX_GAP        = 16;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_in_word         in_word   = '0;
    logic             out_ready = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             in_ready;
    logic             out_valid;
    logic             cfg_ready;
    t_out_word        out_word;

    // Predictor copy of the breakpoint table and of the register.
    logic signed [DATA_W-1:0] knot_x [DEF_MAX_POINTS];
    logic signed [DATA_W-1:0] knot_y [DEF_MAX_POINTS];
    int                       knots_in_use;

    // Interpolated results still owed by the block, oldest first.
    t_out_word interp_due [$];
    t_out_word oldest_due;

    int mismatches      = 0;
    int words_accepted  = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;

    piecewise_linear_map dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Hard limit on the run in case a handshake never completes.
    initial begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("simulation failed");
        $finish;
    end

    function automatic logic [PROD_W-1:0] magnitude(input logic signed [PROD_W-1:0] v);
        return (v < 0) ? -v : v;
    endfunction

    // Expected result of mapping one datum through the current table.
    function automatic t_out_word interpolate_datum(input logic signed [DATA_W-1:0] d);
        t_out_word                r;
        int                       k;
        int                       seg;
        logic signed [PROD_W-1:0] x0;
        logic signed [PROD_W-1:0] y0;
        logic signed [PROD_W-1:0] dx;
        logic signed [PROD_W-1:0] dy;
        logic signed [PROD_W-1:0] dd;
        logic signed [PROD_W-1:0] total;
        logic [PROD_W-1:0]        q;
        logic                     neg;
        r = '0;
        // Scan stops at the first x above the datum; an equal x wins outright.
        for (k = 0; k < knots_in_use; k++) begin
            if (knot_x[k] > d) break;
            if (knot_x[k] == d) begin
                r.mapped_value = knot_y[k];
                return r;
            end
        end
        // Clamp to the end segments so outside data is extrapolated.
        seg = (k == 0) ? 0 : k - 1;
        if (seg > knots_in_use - 2) seg = knots_in_use - 2;
        x0 = knot_x[seg];
        y0 = knot_y[seg];
        dx = knot_x[seg + 1] - x0;
        dy = knot_y[seg + 1] - y0;
        if (dx == 0) begin
            r.mapped_value       = knot_y[seg];
            r.degenerate_segment = 1'b1;
            return r;
        end
        // Exact product, quotient truncated toward zero, then saturated.
        dd  = d - x0;
        neg = ((dd < 0) != (dy < 0)) != (dx < 0);
        q   = (magnitude(dd) * magnitude(dy)) / magnitude(dx);
        if (q > 64'h1_FFFF_FFFF) q = 64'h1_FFFF_FFFF;
        total = neg ? y0 - $signed(q) : y0 + $signed(q);
        if (dd == 0 || dy == 0) total = y0;
        if (total > VAL_MAX) begin
            total       = VAL_MAX;
            r.saturated = 1'b1;
        end else if (total < VAL_MIN) begin
            total       = VAL_MIN;
            r.saturated = 1'b1;
        end
        r.mapped_value = total[DATA_W-1:0];
        return r;
    endfunction

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= ERRORS_SHOWN) $display("%s", msg);
    endtask

    // Receiver side: random stalls at the rate of the current phase.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each accepted result word with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (interp_due.size() == 0) begin
                note_failure($sformatf("result word %h arrived with no map word pending",
                                       out_word));
            end else begin
                oldest_due = interp_due.pop_front();
                if (out_word.mapped_value !== oldest_due.mapped_value)
                    note_failure($sformatf("mapped_value: expected %h, got %h",
                                           oldest_due.mapped_value, out_word.mapped_value));
                if (out_word.degenerate_segment !== oldest_due.degenerate_segment)
                    note_failure($sformatf("degenerate_segment: expected %b, got %b",
                                           oldest_due.degenerate_segment,
                                           out_word.degenerate_segment));
                if (out_word.saturated !== oldest_due.saturated)
                    note_failure($sformatf("saturated: expected %b, got %b",
                                           oldest_due.saturated, out_word.saturated));
            end
        end
    end

    // Offer one word, wait for it to be taken, then update the predictor.
    task automatic send_word(input t_in_word w);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        words_accepted++;
        if (w.operation == OP_MAP) begin
            interp_due.push_back(interpolate_datum(w.datum));
        end else begin
            knot_x[w.point_index] = w.point_x;
            knot_y[w.point_index] = w.point_y;
        end
    endtask

    task automatic load_knot(input int idx, input logic [DATA_W-1:0] x,
                             input logic [DATA_W-1:0] y);
        t_in_word w;
        w.operation   = OP_LOAD;
        w.point_index = INDEX_W'(idx);
        w.point_x     = x;
        w.point_y     = y;
        w.datum       = $urandom();
        send_word(w);
    endtask

    task automatic map_datum(input logic [DATA_W-1:0] d);
        t_in_word w;
        w.operation   = OP_MAP;
        w.point_index = INDEX_W'($urandom_range(15));
        w.point_x     = $urandom();
        w.point_y     = $urandom();
        w.datum       = d;
        send_word(w);
    endtask

    // Wait until every result is in and the block has gone quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (interp_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write, only once the block is idle.
    task automatic write_points(input logic [CFG_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (value < CFG_POINTS_MIN) knots_in_use = CFG_POINTS_MIN;
        else if (value > DEF_MAX_POINTS) knots_in_use = DEF_MAX_POINTS;
        else knots_in_use = value;
    endtask

    // Load a fresh ascending table over every point in use; some x repeat.
    task automatic load_sorted_table();
        logic signed [PROD_W-1:0] pos;
        logic signed [PROD_W-1:0] y_pos;
        logic signed [PROD_W-1:0] step;
        logic [DATA_W-1:0]        span;
        logic [DATA_W-1:0]        x_word;
        int                       k;
        case ($urandom_range(2))
            0: begin
                span = 32'h0000_0400;
            end
            1: begin
                span = 32'h0010_0000;
            end
            default: begin
                span = 32'h0800_0000;
            end
        endcase
        if ($urandom_range(7) == 0) begin
            pos = $signed($urandom());
        end else begin
            pos  = span;
            pos  = -((pos * knots_in_use) / 2);
            step = $urandom_range(span);
            pos  = pos + step;
        end
        y_pos = $signed($urandom());
        for (k = 0; k < knots_in_use; k++) begin
            if (pos > VAL_MAX) x_word = VAL_MAX;
            else if (pos < VAL_MIN) x_word = VAL_MIN;
            else x_word = pos[DATA_W-1:0];
            load_knot(k, x_word, ($urandom_range(1) == 0) ? $urandom() : y_pos[DATA_W-1:0]);
            step  = ($urandom_range(9) == 0) ? 0 : $urandom_range(span, 1);
            pos   = pos + step;
            step  = $signed($urandom()) >>> 6;
            y_pos = y_pos + step;
        end
    endtask

    // Reset table: identity over two points, matches at both ends, far data.
    task automatic test_identity_map();
        map_datum(32'h0000_0000);
        map_datum(32'h0001_0000);
        map_datum(32'h0000_8000);
        map_datum(32'h8000_0000);
        map_datum(32'h7FFF_FFFF);
    endtask

    // Register values below the legal range act as two points.
    task automatic test_register_clamp();
        write_points(5'd0);
        map_datum(32'h0001_8000);
        write_points(5'd1);
        map_datum(32'hFFFF_8000);
    endtask

    // Steep segment drives the result past both ends of the range.
    task automatic test_saturation();
        load_knot(0, 32'h0000_0000, 32'h8000_0000);
        load_knot(1, 32'h0000_0001, 32'h7FFF_FFFF);
        map_datum(32'h7FFF_FFFF);
        map_datum(32'h8000_0000);
        map_datum(32'h0000_0001);
    endtask

    // Zero-width first segment, exact matches, then an unsorted last x.
    task automatic test_degenerate_and_unsorted();
        write_points(5'd3);
        load_knot(0, 32'h0000_0000, 32'h0000_0005);
        load_knot(1, 32'h0000_0000, 32'h0000_0009);
        load_knot(2, 32'h7FFF_FFFF, 32'h8000_0000);
        map_datum(32'hFFFF_FFFB);
        map_datum(32'h0000_0000);
        map_datum(32'h7FFF_FFFF);
        map_datum(32'h4000_0000);
        load_knot(2, 32'hFFFF_0000, 32'h1234_5678);
        map_datum(32'h0001_0000);
    endtask

    // Quotients that must truncate toward zero on both signs.
    task automatic test_rounding();
        write_points(5'd2);
        load_knot(0, 32'h0000_0000, 32'h0000_0000);
        load_knot(1, 32'h0000_0003, 32'h0000_0001);
        load_knot(15, 32'h8000_0000, 32'h7FFF_FFFF);
        map_datum(32'h0000_0002);
        map_datum(32'hFFFF_FFFF);
        map_datum(32'hFFFF_FFFC);
    endtask

    // Mostly maps over freshly sorted tables, with stray loads as noise.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [CFG_W-1:0] first_cfg);
        int                seg;
        int                start;
        int                pick;
        int                k;
        logic [DATA_W-1:0] gap_width;
        logic [DATA_W-1:0] d;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (seg = 0; seg < 3; seg++) begin
            write_points((seg == 0) ? first_cfg : CFG_W'($urandom_range(31)));
            load_sorted_table();
            start = words_accepted;
            while (words_accepted - start < SEGMENT_WORDS) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    load_sorted_table();
                end else if (pick < 16) begin
                    load_knot($urandom_range(15), $urandom(), $urandom());
                end else begin
                    // Data on, between and near breakpoints, plus extremes.
                    pick = $urandom_range(99);
                    k    = $urandom_range(knots_in_use - 2);
                    if (pick < 35) begin
                        d = knot_x[$urandom_range(knots_in_use - 1)];
                    end else if (pick < 70) begin
                        if (knot_x[k + 1] <= knot_x[k]) begin
                            d = knot_x[k];
                        end else begin
                            gap_width = knot_x[k + 1] - knot_x[k];
                            d = knot_x[k] + $urandom_range(gap_width);
                        end
                    end else if (pick < 80) begin
                        d = knot_x[k] + $urandom_range(4) - 2;
                    end else if (pick < 90) begin
                        case ($urandom_range(3))
                            0: begin
                                d = VAL_MIN;
                            end
                            1: begin
                                d = VAL_MAX;
                            end
                            2: begin
                                d = '0;
                            end
                            default: begin
                                d = '1;
                            end
                        endcase
                    end else begin
                        d = $urandom();
                    end
                    map_datum(d);
                end
            end
        end
    endtask

    initial begin
        // Predictor state after reset: identity map over two points.
        foreach (knot_x[i]) begin
            knot_x[i] = '0;
            knot_y[i] = '0;
        end
        knot_x[1]    = 1 << DEF_FRAC_BITS;
        knot_y[1]    = 1 << DEF_FRAC_BITS;
        knots_in_use = CFG_POINTS_MIN;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_identity_map();
        test_register_clamp();
        test_saturation();
        test_degenerate_and_unsorted();
        test_rounding();
        test_random_traffic(0, 0, 5'd31);
        test_random_traffic(50, 0, 5'd17);
        test_random_traffic(0, 50, 5'd16);
        test_random_traffic(38, 38, 5'd2);

        settle();
        if (mismatches == 0 && interp_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
